### sv/rsa_pkg.sv
// rsa_pkg: shared types and constants for the rsa modexp block
// used by rsa_dp, rsa_ctrl and rsa_modexp_with_crt; no dependencies
package rsa_pkg;

	localparam logic [1:0] OP_ENC  = 2'd0;
	localparam logic [1:0] OP_DEC  = 2'd1;
	localparam logic [1:0] OP_CRT  = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_BAD_CFG = 2'd2;

	localparam logic [2:0] REG_PUB = 3'd0;
	localparam logic [2:0] REG_PRV = 3'd1;
	localparam logic [2:0] REG_MOD = 3'd2;
	localparam logic [2:0] REG_P   = 3'd3;
	localparam logic [2:0] REG_Q   = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result;
		logic [1:0]  status;
	} out_item_t;

	// restoring divider command/status
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [31:0] remainder;
	} div_sts_t;

endpackage

### sv/rsa_dp.sv
// rsa_dp: shared restoring divider, one quotient bit a cycle
// depends on rsa_pkg
module rsa_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rsa_pkg::div_cmd_t cmd,
	output rsa_pkg::div_sts_t sts
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
			dsr_q <= cmd.divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign sts.done      = done_q;
	assign sts.quotient  = quo_q;
	assign sts.remainder = rem_q[31:0];

endmodule

### sv/rsa_ctrl.sv
// rsa_ctrl: sequencer for checks, gcd, inverses, exponentiation and crt recombination
// depends on rsa_pkg; drives rsa_dp through div_cmd_t / div_sts_t
module rsa_ctrl #(
	parameter int MOD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  rsa_pkg::in_item_t    item,
	input  logic [31:0]          pub_e,
	input  logic [31:0]          prv_d,
	input  logic [31:0]          modn,
	input  logic [15:0]          pp,
	input  logic [15:0]          pq,
	output rsa_pkg::div_cmd_t    dcmd,
	input  rsa_pkg::div_sts_t    dsts,
	output logic                 idle,
	output logic                 done,
	output rsa_pkg::out_item_t   res
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CHECK  = 5'd1;
	localparam logic [4:0] S_GCD    = 5'd2;
	localparam logic [4:0] S_GCDW   = 5'd3;
	localparam logic [4:0] S_INV    = 5'd4;
	localparam logic [4:0] S_INVW   = 5'd5;
	localparam logic [4:0] S_EXPI   = 5'd6;
	localparam logic [4:0] S_EXPIW  = 5'd7;
	localparam logic [4:0] S_BIT    = 5'd8;
	localparam logic [4:0] S_MULW   = 5'd9;
	localparam logic [4:0] S_SQW    = 5'd10;
	localparam logic [4:0] S_PHASE  = 5'd11;
	localparam logic [4:0] S_COMB1  = 5'd12;
	localparam logic [4:0] S_COMB1W = 5'd13;
	localparam logic [4:0] S_COMB2  = 5'd14;
	localparam logic [4:0] S_COMB2W = 5'd15;
	localparam logic [4:0] S_COMB3  = 5'd16;
	localparam logic [4:0] S_COMB3W = 5'd17;
	localparam logic [4:0] S_OUT    = 5'd18;
	localparam logic [4:0] S_COMB4  = 5'd19;
	localparam logic [4:0] S_COMB4W = 5'd20;

	localparam logic [31:0] MOD_MASK = 32'hFFFF_FFFF >> (32 - MOD_BITS);

	logic [4:0]  state_q;
	logic [1:0]  op_q;
	logic [31:0] val_q;
	logic [31:0] n_q;
	// gcd / extended euclid
	logic [31:0] ga_q, gb_q;
	logic signed [33:0] prev_q, cur_q;
	logic [1:0]  phase_q;     // crt sub-phase: 0 inv q mod p, 1 inv p mod q, 2 exp p, 3 exp q
	logic [31:0] xp_q, xq_q, vp_q;
	// exponentiation
	logic [31:0] m_q, ex_q, acc_q, sq_q, tmp_q;
	logic [31:0] ex_in_q;
	logic [31:0] sum_q;
	rsa_pkg::out_item_t res_q;
	logic done_q;
	logic signed [67:0] prod;
	logic signed [33:0] nxt;

	assign prod = $signed({1'b0, dsts.quotient[33:0]}) * cur_q;
	assign nxt  = prev_q - prod[33:0];

	function automatic logic [31:0] pmod(input logic [15:0] x);
		pmod = {16'd0, x};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			dcmd    <= '0;
		end else begin
			done_q     <= 1'b0;
			dcmd.start <= 1'b0;
			unique case (state_q)
				S_IDLE: if (go) state_q <= S_CHECK;
				S_CHECK: begin
					if (op_q == rsa_pkg::OP_RSVD || n_q < 32'd2) begin
						res_q   <= '{result: '0, status: rsa_pkg::ST_BAD_CFG};
						state_q <= S_OUT;
					end else if (op_q == rsa_pkg::OP_CRT && (pp < 16'd2 || pq < 16'd2)) begin
						res_q   <= '{result: '0, status: rsa_pkg::ST_BAD_CFG};
						state_q <= S_OUT;
					end else if (op_q != rsa_pkg::OP_CRT && val_q >= n_q) begin
						res_q   <= '{result: '0, status: rsa_pkg::ST_RANGE};
						state_q <= S_OUT;
					end else if (op_q == rsa_pkg::OP_CRT) begin
						ga_q    <= pmod(pp);
						gb_q    <= pmod(pq);
						state_q <= S_GCD;
					end else begin
						m_q     <= n_q;
						ex_in_q <= (op_q == rsa_pkg::OP_ENC) ? pub_e : prv_d;
						state_q <= S_EXPI;
					end
				end
				S_GCD: begin
					if (gb_q == 32'd0) begin
						if (ga_q != 32'd1) begin
							res_q   <= '{result: '0, status: rsa_pkg::ST_BAD_CFG};
							state_q <= S_OUT;
						end else if (val_q >= n_q) begin
							res_q   <= '{result: '0, status: rsa_pkg::ST_RANGE};
							state_q <= S_OUT;
						end else begin
							phase_q <= 2'd0;
							ga_q    <= pmod(pq);
							gb_q    <= pmod(pp);
							prev_q  <= 34'sd1;
							cur_q   <= 34'sd0;
							state_q <= S_INV;
						end
					end else begin
						dcmd    <= '{start: 1'b1, dividend: {32'd0, ga_q}, divisor: gb_q};
						state_q <= S_GCDW;
					end
				end
				S_GCDW: if (dsts.done) begin
					ga_q    <= gb_q;
					gb_q    <= dsts.remainder;
					state_q <= S_GCD;
				end
				S_INV: begin
					if (ga_q > 32'd1 && gb_q != 32'd0) begin
						dcmd    <= '{start: 1'b1, dividend: {32'd0, ga_q}, divisor: gb_q};
						state_q <= S_INVW;
					end else begin
						// lift negative coefficient, then scale by the other prime
						if (phase_q == 2'd0) begin
							xp_q    <= 32'(pq) * 32'(prev_q < 0 ? prev_q + 34'(pp) : prev_q);
							ga_q    <= pmod(pp);
							gb_q    <= pmod(pq);
							prev_q  <= 34'sd1;
							cur_q   <= 34'sd0;
							phase_q <= 2'd1;
						end else begin
							xq_q    <= 32'(pp) * 32'(prev_q < 0 ? prev_q + 34'(pq) : prev_q);
							phase_q <= 2'd2;
							m_q     <= pmod(pp);
							state_q <= S_PHASE;
						end
					end
				end
				S_INVW: if (dsts.done) begin
					ga_q    <= gb_q;
					gb_q    <= dsts.remainder;
					prev_q  <= cur_q;
					cur_q   <= nxt;
					state_q <= S_INV;
				end
				S_PHASE: begin
					// reduce d mod (m-1)
					dcmd    <= '{start: 1'b1, dividend: {32'd0, prv_d}, divisor: m_q - 32'd1};
					state_q <= S_COMB4W;
				end
				S_COMB4W: if (dsts.done) begin
					ex_in_q <= dsts.remainder;
					state_q <= S_EXPI;
				end
				S_COMB4: state_q <= S_IDLE;
				S_EXPI: begin
					dcmd    <= '{start: 1'b1, dividend: {32'd0, val_q}, divisor: m_q};
					state_q <= S_EXPIW;
				end
				S_EXPIW: if (dsts.done) begin
					sq_q    <= dsts.remainder;
					acc_q   <= 32'd1;
					ex_q    <= ex_in_q;
					state_q <= S_BIT;
				end
				S_BIT: begin
					if (ex_q == 32'd0) begin
						// acc % m with acc=1 and m=1 impossible here as m>=2
						if (op_q != rsa_pkg::OP_CRT) begin
							res_q   <= '{result: acc_q, status: rsa_pkg::ST_OK};
							state_q <= S_OUT;
						end else if (phase_q == 2'd2) begin
							vp_q    <= acc_q;
							phase_q <= 2'd3;
							m_q     <= pmod(pq);
							state_q <= S_PHASE;
						end else begin
							tmp_q   <= acc_q;
							state_q <= S_COMB1;
						end
					end else if (ex_q[0]) begin
						dcmd    <= '{start: 1'b1, dividend: 64'(acc_q) * 64'(sq_q), divisor: m_q};
						state_q <= S_MULW;
					end else begin
						dcmd    <= '{start: 1'b1, dividend: 64'(sq_q) * 64'(sq_q), divisor: m_q};
						state_q <= S_SQW;
					end
				end
				S_MULW: if (dsts.done) begin
					acc_q   <= dsts.remainder;
					dcmd    <= '{start: 1'b1, dividend: 64'(sq_q) * 64'(sq_q), divisor: m_q};
					state_q <= S_SQW;
				end
				S_SQW: if (dsts.done) begin
					sq_q    <= dsts.remainder;
					ex_q    <= ex_q >> 1;
					state_q <= S_BIT;
				end
				S_COMB1: begin
					dcmd    <= '{start: 1'b1, dividend: 64'(vp_q) * 64'(xp_q), divisor: n_q};
					state_q <= S_COMB1W;
				end
				S_COMB1W: if (dsts.done) begin
					sum_q   <= dsts.remainder;
					state_q <= S_COMB2;
				end
				S_COMB2: begin
					dcmd    <= '{start: 1'b1, dividend: 64'(tmp_q) * 64'(xq_q), divisor: n_q};
					state_q <= S_COMB2W;
				end
				S_COMB2W: if (dsts.done) begin
					tmp_q   <= dsts.remainder;
					state_q <= S_COMB3;
				end
				S_COMB3: begin
					dcmd    <= '{start: 1'b1, dividend: 64'(sum_q) + 64'(tmp_q), divisor: n_q};
					state_q <= S_COMB3W;
				end
				S_COMB3W: if (dsts.done) begin
					res_q   <= '{result: dsts.remainder, status: rsa_pkg::ST_OK};
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && go) begin
			op_q  <= item.operation;
			val_q <= item.value;
			n_q   <= modn & MOD_MASK;
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> idle)
		else $error("done outside idle");
	assert property (@(posedge clk) disable iff (!arst_n) dcmd.start |-> !idle)
		else $error("divider started while idle");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

### sv/rsa_modexp_with_crt.sv
// rsa_modexp_with_crt: top level, config registers, sequencer and divider
// depends on rsa_pkg, rsa_ctrl, rsa_dp
//
// channel  | handshake            | payload
// cmd      | start / busy         | in_item (operation, value)
// result   | done strobe          | out_item (result, status)
// config   | cfg_valid/cfg_ready  | cfg_index, cfg_data (ready only while idle, no start)
//
// one item at a time; busy is high from the accepting edge until the result strobe
// encrypt/decrypt use one divider pass to reduce the value, then a square per exponent
// bit and a multiply per set bit: up to 65 passes for a 32-bit exponent; crt adds gcd,
// inverse, exponent-reduction and three recombination passes around two exponentiations
// with exponents under 16 bits
// reset restores the register defaults; no clearing pass; the result strobe lasts one
// cycle and cannot be held off
module rsa_modexp_with_crt #(
	parameter int MOD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rsa_pkg::in_item_t  in_item,
	output logic               done,
	output rsa_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0] pub_q, prv_q, mod_q;
	logic [15:0] p_q, q_q;
	logic        idle;
	rsa_pkg::div_cmd_t dcmd;
	rsa_pkg::div_sts_t dsts;

	// config transfers only between items, never alongside a command transfer
	assign cfg_ready = idle & ~start;
	assign busy      = !idle;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_q <= 32'd65537;
			prv_q <= 32'd1;
			mod_q <= 32'd2114591959;
			p_q   <= 16'd48907;
			q_q   <= 16'd43237;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rsa_pkg::REG_PUB: pub_q <= cfg_data;
				rsa_pkg::REG_PRV: prv_q <= cfg_data;
				rsa_pkg::REG_MOD: mod_q <= cfg_data;
				rsa_pkg::REG_P:   p_q   <= cfg_data[15:0];
				rsa_pkg::REG_Q:   q_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rsa_ctrl #(.MOD_BITS(MOD_BITS)) u_ctrl (
		.clk, .arst_n,
		.go(start), .item(in_item),
		.pub_e(pub_q), .prv_d(prv_q), .modn(mod_q), .pp(p_q), .pq(q_q),
		.dcmd, .dsts, .idle, .done, .res(out_item)
	);

	rsa_dp u_dp (.clk, .arst_n, .cmd(dcmd), .sts(dsts));

endmodule
